FILE: hdl/aetu_pkg.sv
// Package for the address-event timestamp unwrapper.
// Holds the marker codes, output word constants and the command word type.
// No dependencies.
package aetu_pkg;

  // Raw time codes that act as control markers.
  localparam logic [15:0] SubwrapCode = 16'h8000;
  localparam logic [15:0] ResetCode   = 16'h4000;

  // Output word constants.
  localparam logic [31:0] WrapMarkerWord = 32'h8800_0000;
  localparam logic [7:0]  TsTag          = 8'h80;

  // Field widths.
  localparam int unsigned AddrW  = 16;
  localparam int unsigned TimeW  = 16;
  localparam int unsigned LowW   = 14;
  localparam int unsigned CountW = 11;
  localparam int unsigned EmitW  = 10;
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // Command queue between the front and back parts.
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

  // One classified event, ready to be serialized into words.
  typedef struct packed {
    logic             wrap;
    logic [EmitW-1:0] count;
    logic [LowW-1:0]  low_time;
    logic [AddrW-1:0] addr;
  } cmd_t;

  // Status of the command queue as the back part sees it.
  typedef struct packed {
    logic empty;
    cmd_t head;
  } fifo_stat_t;

endpackage

FILE: hdl/aetu_front.sv
// Front part of the timestamp unwrapper: accepts raw events, keeps the wrap state.
// Depends on aetu_pkg.
module aetu_front
  import aetu_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  input  logic [AddrW-1:0] pixel_address_i,
  input  logic [TimeW-1:0] raw_time_i,
  input  logic             queue_full_i,
  output logic             full,
  output logic             cmd_push_o,
  output cmd_t             cmd_o
);

  logic [CountW-1:0] wrap_count_q, wrap_count_d;
  logic [TimeW-1:0]  prev_time_q, prev_time_d;
  logic              subwrap_q, subwrap_d;

  logic              accept;
  logic              is_zero, is_sub, is_rst, is_normal;
  logic [CountW-1:0] bumped, stepped;
  logic              do_wrap;

  assign full   = queue_full_i;
  assign accept = push && !queue_full_i;

  // Classify the incoming word.
  assign is_zero   = (pixel_address_i == '0) && (raw_time_i == '0);
  assign is_sub    = !is_zero && (raw_time_i == SubwrapCode);
  assign is_rst    = !is_zero && (raw_time_i == ResetCode);
  assign is_normal = !is_zero && !is_sub && !is_rst;

  // Saturating increment of the wrap count.
  assign bumped = (wrap_count_q == CountMax) ? CountMax : wrap_count_q + 1'b1;

  // A normal event counts a wrap when time went backward without a sub-wrap marker.
  assign stepped = ((raw_time_i < prev_time_q) && !subwrap_q) ? bumped : wrap_count_q;
  assign do_wrap = stepped[CountW-1];

  // Next state. All-zero words leave the state unchanged.
  always_comb begin
    wrap_count_d = wrap_count_q;
    prev_time_d  = prev_time_q;
    subwrap_d    = subwrap_q;
    if (accept && !is_zero) begin
      priority if (is_sub) begin
        wrap_count_d = bumped;
        subwrap_d    = 1'b1;
      end else if (is_rst) begin
        wrap_count_d = '0;
      end else begin
        wrap_count_d = do_wrap ? '0 : stepped;
        subwrap_d    = 1'b0;
        prev_time_d  = raw_time_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_count_q <= '0;
      prev_time_q  <= '0;
      subwrap_q    <= 1'b0;
    end else begin
      wrap_count_q <= wrap_count_d;
      prev_time_q  <= prev_time_d;
      subwrap_q    <= subwrap_d;
    end
  end

  // Command for the back part; only normal events produce words.
  assign cmd_push_o     = accept && is_normal;
  assign cmd_o.wrap     = do_wrap;
  assign cmd_o.count    = do_wrap ? '0 : stepped[EmitW-1:0];
  assign cmd_o.low_time = raw_time_i[LowW-1:0];
  assign cmd_o.addr     = pixel_address_i;

endmodule

FILE: hdl/aetu_fifo.sv
// Short command queue between the front and back parts of the unwrapper.
// Depends on aetu_pkg.
module aetu_fifo
  import aetu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_en_i,
  input  cmd_t       wr_data_i,
  input  logic       rd_en_i,
  output logic       full_o,
  output fifo_stat_t stat_o
);

  cmd_t            mem_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            empty;

  assign full_o = (count_q == CntW'(FifoDepth));
  assign empty  = (count_q == '0);

  // Storage; entries need no reset.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_en_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_en_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({wr_en_i, rd_en_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  assign stat_o.empty = empty;
  assign stat_o.head  = mem_q[rd_ptr_q];

`ifndef SYNTHESIS
  // The front part must never write into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) wr_en_i |-> !full_o)
    else $error("command queue overflow");

  // The back part must never read an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) rd_en_i |-> !empty)
    else $error("command queue underflow");

  // The fill count stays within the depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(FifoDepth))
    else $error("command queue count out of range");
`endif

endmodule

FILE: hdl/aetu_back.sv
// Back part of the unwrapper: turns queued commands into output words.
// Depends on aetu_pkg.
module aetu_back
  import aetu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  fifo_stat_t  stat_i,
  output logic        rd_en_o,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_word_o,
  output logic        last_of_run_o
);

  // Which word of the head command goes out next.
  localparam logic [1:0] PhFirst = 2'd0;
  localparam logic [1:0] PhTs    = 2'd1;
  localparam logic [1:0] PhAddr  = 2'd2;

  logic [1:0]  phase_q, phase_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] word_q, word_d;
  logic        last_q, last_d;
  logic        load;
  logic [31:0] ts_word, addr_word;

  // The output register takes a new word when it is empty or being drained.
  assign load = !stat_i.empty && (!out_valid_q || pop);

  assign ts_word   = {TsTag, stat_i.head.count, stat_i.head.low_time};
  assign addr_word = {16'h0000, stat_i.head.addr};

  // Word selection and phase sequencing.
  always_comb begin
    phase_d = phase_q;
    word_d  = word_q;
    last_d  = last_q;
    rd_en_o = 1'b0;
    if (load) begin
      unique case (phase_q)
        PhTs: begin
          word_d  = ts_word;
          last_d  = 1'b0;
          phase_d = PhAddr;
        end
        PhAddr: begin
          word_d  = addr_word;
          last_d  = 1'b1;
          phase_d = PhFirst;
          rd_en_o = 1'b1;
        end
        default: begin
          last_d = 1'b0;
          if (stat_i.head.wrap) begin
            word_d  = WrapMarkerWord;
            phase_d = PhTs;
          end else begin
            word_d  = ts_word;
            phase_d = PhAddr;
          end
        end
      endcase
    end
  end

  // Valid flag of the output register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhFirst;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    last_q <= last_d;
  end

  assign empty         = !out_valid_q;
  assign out_word_o    = word_q;
  assign last_of_run_o = last_q;

endmodule

FILE: hdl/address_event_timestamp_unwrapper_unit.sv
// Address-event timestamp unwrapper, top level. Each accepted event with an ordinary time
// word yields two 32-bit words (timestamp, then address), or three when a wrap marker
// word leads; marker and all-zero events yield none. One word leaves per cycle from the
// output register while pop is held. The front part accepts one event per cycle, while
// full is low, into a four-entry command queue, so full rises only when that queue backs
// up behind the output side.
// Depends on aetu_pkg, aetu_front, aetu_fifo and aetu_back.
module address_event_timestamp_unwrapper_unit
  import aetu_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic [AddrW-1:0] pixel_address_i,
  input  logic [TimeW-1:0] raw_time_i,
  output logic             empty,
  input  logic             pop,
  output logic [31:0]      out_word_o,
  output logic             last_of_run_o
);

  logic       queue_full;
  logic       cmd_push;
  cmd_t       cmd;
  logic       cmd_pop;
  fifo_stat_t stat;

  // Classification and wrap state.
  aetu_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .pixel_address_i (pixel_address_i),
    .raw_time_i      (raw_time_i),
    .queue_full_i    (queue_full),
    .full            (full),
    .cmd_push_o      (cmd_push),
    .cmd_o           (cmd)
  );

  // Command queue.
  aetu_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cmd_push),
    .wr_data_i (cmd),
    .rd_en_i   (cmd_pop),
    .full_o    (queue_full),
    .stat_o    (stat)
  );

  // Word serializer and output register.
  aetu_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stat_i        (stat),
    .rd_en_o       (cmd_pop),
    .empty         (empty),
    .pop           (pop),
    .out_word_o    (out_word_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

FILE: tb/sv/tb_address_event_timestamp_unwrapper_unit.sv
`timescale 1ns / 1ps
// Testbench for address_event_timestamp_unwrapper_unit: drives raw events through the push
// side, predicts the emitted words in the bench and checks every popped word against them.
// Depends on aetu_pkg and address_event_timestamp_unwrapper_unit.
module tb_address_event_timestamp_unwrapper_unit
  import aetu_pkg::*;
();

  localparam int unsigned WrapLimit  = 1024;
  localparam int unsigned MaxGap     = 5;
  localparam int unsigned StallLen   = 150;
  localparam int unsigned DrainLen   = 24;
  localparam int unsigned CycleLimit = 40000;
  localparam int unsigned MaxReports = 10;

  // One emitted word as the output side presents it.
  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } out_word_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             push = 1'b0;
  logic             full;
  logic [AddrW-1:0] pixel_address_i = '0;
  logic [TimeW-1:0] raw_time_i = '0;
  logic             empty;
  logic             pop = 1'b0;
  logic [31:0]      out_word_o;
  logic             last_of_run_o;

  // Unwrapper state as the bench tracks it.
  logic [CountW-1:0] wrap_cnt = '0;
  logic [TimeW-1:0]  prev_time = '0;
  logic              subwrap_armed = 1'b0;

  out_word_t   expected_words[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  logic [TimeW-1:0] last_sent_time = '0;
  bit stall_request = 1'b0;
  bit burst_mode = 1'b0;

  address_event_timestamp_unwrapper_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .pixel_address_i(pixel_address_i),
    .raw_time_i     (raw_time_i),
    .empty          (empty),
    .pop            (pop),
    .out_word_o     (out_word_o),
    .last_of_run_o  (last_of_run_o)
  );

  always #4 clk_i = ~clk_i;

  // Hard limit on the run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("address_event_timestamp_unwrapper_unit verification failed");
      $finish;
    end
  end

  // Idle cycles before the next handshake; none while a burst is running.
  function automatic int unsigned draw_gap();
    if (burst_mode) return 0;
    return $urandom_range(0, MaxGap);
  endfunction

  // Applies one accepted event to the tracked state and queues the words it emits.
  function automatic void unwrap_event(logic [AddrW-1:0] addr, logic [TimeW-1:0] tm);
    logic [31:0] stamp;
    if (addr == '0 && tm == '0) return;
    if (tm == SubwrapCode) begin
      subwrap_armed = 1'b1;
      if (wrap_cnt != CountMax) wrap_cnt = wrap_cnt + 1'b1;
      return;
    end
    if (tm == ResetCode) begin
      wrap_cnt = '0;
      return;
    end
    if (tm < prev_time && !subwrap_armed && wrap_cnt != CountMax) wrap_cnt = wrap_cnt + 1'b1;
    subwrap_armed = 1'b0;
    if (wrap_cnt >= WrapLimit) begin
      wrap_cnt = '0;
      expected_words.push_back('{WrapMarkerWord, 1'b0});
    end
    stamp = {TsTag, 24'h0} | (32'(tm[LowW-1:0]) + (32'(wrap_cnt) << LowW));
    prev_time = tm;
    expected_words.push_back('{stamp, 1'b0});
    expected_words.push_back('{32'(addr), 1'b1});
  endfunction

  // Offers one event after a random gap and returns at the edge that accepts it.
  task automatic send_event(input logic [AddrW-1:0] addr, input logic [TimeW-1:0] tm);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    pixel_address_i <= addr;
    raw_time_i <= tm;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    unwrap_event(addr, tm);
    last_sent_time = tm;
  endtask

  // Pops words with random gaps; a stall request holds pop low for a long stretch.
  initial begin
    int unsigned gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (stall_request) begin
        stall_request = 1'b0;
        pop <= 1'b0;
        repeat (StallLen) @(posedge clk_i);
      end
      gap = draw_gap();
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
    end
  end

  // Compares each popped word with the oldest expected one.
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && pop && !empty) begin
      if (expected_words.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < MaxReports)
          $display("unexpected word: out_word=%h last=%b", out_word_o, last_of_run_o);
      end else begin
        want = expected_words.pop_front();
        if (out_word_o !== want.word || last_of_run_o !== want.last) begin
          mismatches <= mismatches + 1;
          if (mismatches < MaxReports)
            $display("word mismatch: expected %h/%b, got %h/%b",
                     want.word, want.last, out_word_o, last_of_run_o);
        end
      end
    end
  end

  // Field extremes, both markers, the dropped item and the wrap rules.
  task automatic test_directed_cases();
    send_event(16'h0000, 16'h0000);
    send_event(16'h0000, 16'h0001);
    send_event(16'hFFFF, 16'h3FFF);
    send_event(16'h1234, 16'h0005);
    send_event(16'hABCD, SubwrapCode);
    send_event(16'h0001, 16'h0002);
    send_event(16'h0002, 16'h0001);
    send_event(16'hFFFF, ResetCode);
    send_event(16'h5555, 16'hFFFF);
    send_event(16'hAAAA, 16'h0000);
    send_event(16'h0000, 16'hC000);
    send_event(16'h00FF, 16'h7FFF);
    send_event(16'hFF00, 16'hBFFF);
    send_event(16'h8001, SubwrapCode);
    send_event(16'h0000, SubwrapCode);
    send_event(16'h7FFE, 16'h0100);
    send_event(16'h0000, ResetCode);
    send_event(16'h4321, 16'h0050);
    send_event(16'h0000, 16'h0000);
  endtask

  // Wrap count steps: several sub-wraps, a backward step with and without a sub-wrap
  // before it, an equal time, and a reset marker in between.
  task automatic test_wrap_count_limits();
    send_event(16'h0000, ResetCode);
    repeat (3) send_event(16'($urandom), SubwrapCode);
    send_event(16'h0102, 16'h0010);
    send_event(16'h0304, 16'h0008);
    send_event(16'h0506, 16'h0008);
    send_event(16'h0000, ResetCode);
    send_event(16'h0708, 16'h0004);
    send_event(16'h090A, SubwrapCode);
    send_event(16'h0B0C, 16'h0002);
    send_event(16'h0D0E, 16'h3FFF);
  endtask

  // Mostly rising time with random wraps, plus markers, dropped items and noise.
  task automatic test_random_traffic();
    int unsigned pick;
    logic [TimeW-1:0] tm;
    for (int i = 0; i < 210; i++) begin
      burst_mode = (i >= 100 && i < 160);
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        send_event(16'h0000, 16'h0000);
      end else if (pick < 11) begin
        send_event(16'($urandom), SubwrapCode);
      end else if (pick < 15) begin
        send_event(16'($urandom), ResetCode);
      end else if (pick < 60) begin
        tm = last_sent_time + 16'($urandom_range(1, 600));
        send_event(16'($urandom), tm);
      end else begin
        send_event(16'($urandom), 16'($urandom));
      end
    end
    burst_mode = 1'b0;
  endtask

  // The output side stalls for a long stretch while events keep coming back to back.
  task automatic test_output_backpressure();
    stall_request = 1'b1;
    burst_mode = 1'b1;
    for (int i = 0; i < 40; i++)
      send_event(16'($urandom), 16'($urandom_range(1, 16'h3FFF)));
    burst_mode = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_wrap_count_limits();
    test_random_traffic();
    test_output_backpressure();
    push <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DrainLen) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("address_event_timestamp_unwrapper_unit verification clean");
    end else begin
      $display("address_event_timestamp_unwrapper_unit verification failed");
    end
    $finish;
  end

endmodule

FILE: address_event_timestamp_unwrapper_unit.f
hdl/aetu_pkg.sv
hdl/aetu_front.sv
hdl/aetu_fifo.sv
hdl/aetu_back.sv
hdl/address_event_timestamp_unwrapper_unit.sv
tb/sv/tb_address_event_timestamp_unwrapper_unit.sv
